// ===== hw/rtl/fifth_order_sigma_delta_modulator_defines.svh =====
// Assertion macros for the fifth-order sigma-delta modulator.
// Used by the top level; expects clock and reset in the scope of each use.
`ifndef FIFTH_ORDER_SIGMA_DELTA_MODULATOR_DEFINES_SVH
`define FIFTH_ORDER_SIGMA_DELTA_MODULATOR_DEFINES_SVH

// same-cycle implication on clock, disabled during reset
`define FOSDM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sigma-delta modulator check failed");

// next-cycle implication on clock, disabled during reset
`define FOSDM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sigma-delta modulator check failed");

`endif

// ===== hw/rtl/fosdm_pkg.sv =====
// Shared types and constants of the fifth-order sigma-delta modulator.
// Used by fosdm_core and the top level; depends on nothing.
package fosdm_pkg;

   localparam int COUNT_BITS_DEFAULT = 32;
   localparam int NSTAGES = 5;

   localparam int SAMPLE_W = 24;
   localparam int GAIN_W = 14;
   localparam int LIMIT_W = 23;
   localparam int GAINED_W = 21;
   localparam int STATE_W = 24;
   localparam int UNCLIP_W = 26;
   localparam int MAG_W = 25;
   localparam int COEF_W = 17;
   localparam int GAIN_SHIFT = 18;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 14'd3277;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd6553600;
   localparam logic [LIMIT_W-1:0] LIMIT_MIN = 23'd65536;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = 23'd6553600;

   localparam logic [COEF_W-1:0] FB_COEF [NSTAGES] = '{
      17'd65536, 17'd40632, 17'd10486, 17'd1638, 17'd98
   };

   typedef enum logic [1:0] {
      FB_ZERO,
      FB_POS,
      FB_NEG
   } fb_type;

   typedef enum logic {
      REG_INPUT_GAIN = 1'b0,
      REG_CLIP_LIMIT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic              dsd_bit;
      logic [NSTAGES-1:0] clip_mask;
      logic [MAG_W-1:0]  stage_peak;
      logic [31:0]       stage_clip_count;
      logic [MAG_W-1:0]  stress_peak;
      logic [31:0]       period_samples;
      logic [31:0]       period_clip_events;
   } rsp_type;

endpackage

// ===== hw/rtl/fifth_order_sigma_delta_modulator.sv =====
// Top level of the fifth-order one-bit sigma-delta modulator.
// Depends on fosdm_pkg, fosdm_core and the assertion macro header.
//
// One audio sample per request, one DSD bit plus period statistics per response.
// The block takes a request every clock and presents its response from the response register:
// on the edge that takes the request the input gain is applied (multiplier into the input
// register), then, once the response register can take it, the five-stage integrator loop
// runs with clipping and quantizing into the response register. That loop, closed through
// the registered feedback, sets the rate at one sample per clock; a request waits only while
// both registers are full and the response is not taken. Reset clears the integrators,
// feedback and statistics at once; the user is to write registers input_gain (address 0) and
// clip_limit (address 4) only while idle; the block itself does not enforce it.
`include "fifth_order_sigma_delta_modulator_defines.svh"

module fifth_order_sigma_delta_modulator #(
   parameter int COUNT_BITS = fosdm_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [fosdm_pkg::SAMPLE_W-1:0] req_audio_sample,
   input  logic                                  req_clear_period,
   input  logic [2:0]                            req_report_stage,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_dsd_bit,
   output logic [4:0]                            rsp_clip_mask,
   output logic [24:0]                           rsp_stage_peak,
   output logic [31:0]                           rsp_stage_clip_count,
   output logic [24:0]                           rsp_stress_peak,
   output logic [31:0]                           rsp_period_samples,
   output logic [31:0]                           rsp_period_clip_events,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [2:0]                            csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import fosdm_pkg::*;

   logic [GAIN_W-1:0]          gain_ff;
   logic [LIMIT_W-1:0]         limit_ff;
   logic [LIMIT_W-1:0]         limit_eff;
   logic                       csr_write;
   reg_index_type              csr_index;

   logic signed [SAMPLE_W+GAIN_W:0] product;
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic signed [GAINED_W-1:0] s1_gained_ff;
   logic                       s1_clear_ff;
   logic [2:0]                 s1_sel_ff;

   logic                       req_fire;
   logic                       out_load;
   logic                       step;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   rsp_type                    rsp_ff;
   rsp_type                    core_result;

   assign csr_pready = 1'b1;
   assign csr_index = reg_index_type'(csr_paddr[2]);
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      unique case (csr_index)
         REG_INPUT_GAIN: csr_prdata = 32'(gain_ff);
         REG_CLIP_LIMIT: csr_prdata = 32'(limit_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_INPUT_GAIN: gain_ff <= csr_pwdata[GAIN_W-1:0];
            REG_CLIP_LIMIT: limit_ff <= csr_pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (limit_ff < LIMIT_MIN) begin
         limit_eff = LIMIT_MIN;
      end else if (limit_ff > LIMIT_MAX) begin
         limit_eff = LIMIT_MAX;
      end else begin
         limit_eff = limit_ff;
      end
   end

   assign out_load = ~rsp_valid_ff | rsp_ready;
   assign step = s1_valid_ff & out_load;
   assign req_ready = ~s1_valid_ff | out_load;
   assign req_fire = req_valid & req_ready;
   assign product = (SAMPLE_W+GAIN_W+1)'(req_audio_sample) * signed'({1'b0, gain_ff});

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_gained_ff <= product[GAIN_SHIFT+GAINED_W-1:GAIN_SHIFT];
         s1_clear_ff <= req_clear_period;
         s1_sel_ff <= req_report_stage;
      end
      if (step) begin
         rsp_ff <= core_result;
      end
   end

   fosdm_core #(
      .COUNT_BITS(COUNT_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .gained (s1_gained_ff),
      .clear  (s1_clear_ff),
      .sel    (s1_sel_ff),
      .limit  (limit_eff),
      .result (core_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_dsd_bit = rsp_ff.dsd_bit;
   assign rsp_clip_mask = rsp_ff.clip_mask;
   assign rsp_stage_peak = rsp_ff.stage_peak;
   assign rsp_stage_clip_count = rsp_ff.stage_clip_count;
   assign rsp_stress_peak = rsp_ff.stress_peak;
   assign rsp_period_samples = rsp_ff.period_samples;
   assign rsp_period_clip_events = rsp_ff.period_clip_events;

   `FOSDM_ASSERT_NOW(a_samples_counted, rsp_valid, rsp_period_samples != 32'd0)
   `FOSDM_ASSERT_NOW(a_clip_event_counted, rsp_valid && |rsp_clip_mask, |rsp_period_clip_events)
   `FOSDM_ASSERT_NOW(a_stress_covers_stage, rsp_valid, rsp_stress_peak >= rsp_stage_peak)
   `FOSDM_ASSERT_NOW(a_ready_only_blocked, !req_ready, s1_valid_ff && rsp_valid_ff && !rsp_ready)
   `FOSDM_ASSERT_NEXT(a_step_fills_output, step, rsp_valid)

endmodule

// ===== hw/rtl/fosdm_core.sv =====
// Integrator cascade, clipping, quantizer and period statistics.
// Depends on fosdm_pkg; state advances on step, the result is combinational.
module fosdm_core #(
   parameter int COUNT_BITS = fosdm_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    step,
   input  logic signed [fosdm_pkg::GAINED_W-1:0]   gained,
   input  logic                                    clear,
   input  logic [2:0]                              sel,
   input  logic [fosdm_pkg::LIMIT_W-1:0]           limit,
   output fosdm_pkg::rsp_type                      result
);
   import fosdm_pkg::*;

   logic signed [STATE_W-1:0]  integ_ff [NSTAGES];
   logic signed [STATE_W-1:0]  integ_in [NSTAGES];
   fb_type                     fb_ff;
   fb_type                     fb_in;
   logic [MAG_W-1:0]           peak_ff [NSTAGES];
   logic [MAG_W-1:0]           peak_in [NSTAGES];
   logic [COUNT_BITS-1:0]      clip_cnt_ff [NSTAGES];
   logic [COUNT_BITS-1:0]      clip_cnt_in [NSTAGES];
   logic [MAG_W-1:0]           overall_ff;
   logic [MAG_W-1:0]           overall_in;
   logic [COUNT_BITS-1:0]      samples_ff;
   logic [COUNT_BITS-1:0]      samples_in;
   logic [COUNT_BITS-1:0]      events_ff;
   logic [COUNT_BITS-1:0]      events_in;

   logic signed [UNCLIP_W-1:0] unclip [NSTAGES];
   logic [MAG_W-1:0]           mag [NSTAGES];
   logic [NSTAGES-1:0]         clip;
   logic                       dsd;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      return (&c) ? c : c + COUNT_BITS'(1);
   endfunction

   function automatic logic [31:0] rep32(input logic [COUNT_BITS-1:0] c);
      logic [63:0] w;
      w = 64'(c);
      return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
   endfunction

   always_comb begin
      logic signed [UNCLIP_W:0] prev;
      logic signed [UNCLIP_W:0] term;
      logic signed [UNCLIP_W:0] sum;
      logic [MAG_W-1:0]         ov;
      prev = (UNCLIP_W+1)'(gained);
      ov = overall_ff;
      for (int i = 0; i < NSTAGES; i++) begin
         unique case (fb_ff)
            FB_POS:  term = signed'({{(UNCLIP_W+1-COEF_W){1'b0}}, FB_COEF[i]});
            FB_NEG:  term = -signed'({{(UNCLIP_W+1-COEF_W){1'b0}}, FB_COEF[i]});
            FB_ZERO: term = '0;
            default: term = '0;
         endcase
         sum = (UNCLIP_W+1)'(integ_ff[i]) + prev - term;
         unclip[i] = sum[UNCLIP_W-1:0];
         prev = (UNCLIP_W+1)'(unclip[i]);
         mag[i] = unclip[i][UNCLIP_W-1] ? MAG_W'(-unclip[i]) : unclip[i][MAG_W-1:0];
         clip[i] = (mag[i] >= MAG_W'(limit));
         if (clip[i]) begin
            integ_in[i] = unclip[i][UNCLIP_W-1] ? -STATE_W'(limit) : STATE_W'(limit);
         end else begin
            integ_in[i] = unclip[i][STATE_W-1:0];
         end
         peak_in[i] = (mag[i] > peak_ff[i]) ? mag[i] : peak_ff[i];
         clip_cnt_in[i] = clip[i] ? sat_inc(clip_cnt_ff[i]) : clip_cnt_ff[i];
         if (mag[i] > ov) begin
            ov = mag[i];
         end
      end
      overall_in = ov;
      samples_in = sat_inc(samples_ff);
      events_in = (|clip) ? sat_inc(events_ff) : events_ff;
      dsd = ~unclip[NSTAGES-1][UNCLIP_W-1];
      fb_in = dsd ? FB_POS : FB_NEG;
   end

   always_comb begin
      result.dsd_bit = dsd;
      result.clip_mask = clip;
      if (sel < 3'(NSTAGES)) begin
         result.stage_peak = peak_in[sel];
         result.stage_clip_count = rep32(clip_cnt_in[sel]);
      end else begin
         result.stage_peak = '0;
         result.stage_clip_count = '0;
      end
      result.stress_peak = overall_in;
      result.period_samples = rep32(samples_in);
      result.period_clip_events = rep32(events_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff <= FB_ZERO;
         overall_ff <= '0;
         samples_ff <= '0;
         events_ff <= '0;
         for (int i = 0; i < NSTAGES; i++) begin
            integ_ff[i] <= '0;
            peak_ff[i] <= '0;
            clip_cnt_ff[i] <= '0;
         end
      end else if (step) begin
         fb_ff <= fb_in;
         for (int i = 0; i < NSTAGES; i++) begin
            integ_ff[i] <= integ_in[i];
         end
         if (clear) begin
            overall_ff <= '0;
            samples_ff <= '0;
            events_ff <= '0;
            for (int i = 0; i < NSTAGES; i++) begin
               peak_ff[i] <= '0;
               clip_cnt_ff[i] <= '0;
            end
         end else begin
            overall_ff <= overall_in;
            samples_ff <= samples_in;
            events_ff <= events_in;
            for (int i = 0; i < NSTAGES; i++) begin
               peak_ff[i] <= peak_in[i];
               clip_cnt_ff[i] <= clip_cnt_in[i];
            end
         end
      end
   end

endmodule

// ===== tb/sv/fosdm_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the fifth-order sigma-delta modulator: tracks the registers,
// predicts each response from the accepted requests and compares it field by field.
// Depends on fosdm_pkg.

module fosdm_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [fosdm_pkg::SAMPLE_W-1:0] req_audio_sample,
   input  logic                                  req_clear_period,
   input  logic [2:0]                            req_report_stage,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic                                  rsp_dsd_bit,
   input  logic [4:0]                            rsp_clip_mask,
   input  logic [24:0]                           rsp_stage_peak,
   input  logic [31:0]                           rsp_stage_clip_count,
   input  logic [24:0]                           rsp_stress_peak,
   input  logic [31:0]                           rsp_period_samples,
   input  logic [31:0]                           rsp_period_clip_events,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [2:0]                            csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   input  logic                                  csr_pready,
   output int                                    error_count,
   output int                                    pending_count
);
   import fosdm_pkg::*;

   logic [GAIN_W-1:0]          gain_q;
   logic [LIMIT_W-1:0]         limit_q;
   logic signed [STATE_W-1:0]  integ_q [NSTAGES];
   fb_type                     feedback_q;
   logic [MAG_W-1:0]           peak_q [NSTAGES];
   logic [31:0]                clip_cnt_q [NSTAGES];
   logic [MAG_W-1:0]           stress_q;
   logic [31:0]                samples_q;
   logic [31:0]                events_q;
   rsp_type                    expected_q [$];

   function automatic logic [31:0] sat_inc(input logic [31:0] c);
      return (c == '1) ? c : c + 32'd1;
   endfunction

   task automatic clear_stats();
      for (int i = 0; i < NSTAGES; i++) begin
         peak_q[i] = '0;
         clip_cnt_q[i] = '0;
      end
      stress_q = '0;
      samples_q = '0;
      events_q = '0;
   endtask

   task automatic modulate(input logic signed [SAMPLE_W-1:0] sample, input logic clear,
                           input logic [2:0] sel, output rsp_type r);
      longint lim;
      longint prev;
      longint fb;
      longint mag;
      longint unclipped [NSTAGES];
      logic [NSTAGES-1:0] mask;
      lim = longint'(limit_q);
      if (lim < longint'(LIMIT_MIN)) lim = longint'(LIMIT_MIN);
      if (lim > longint'(LIMIT_MAX)) lim = longint'(LIMIT_MAX);
      samples_q = sat_inc(samples_q);
      prev = (longint'(sample) * longint'(gain_q)) >>> GAIN_SHIFT;
      for (int i = 0; i < NSTAGES; i++) begin
         fb = (feedback_q == FB_POS) ? longint'(FB_COEF[i]) :
              (feedback_q == FB_NEG) ? -longint'(FB_COEF[i]) : 0;
         unclipped[i] = longint'(integ_q[i]) + prev - fb;
         prev = unclipped[i];
      end
      mask = '0;
      for (int i = 0; i < NSTAGES; i++) begin
         mag = (unclipped[i] < 0) ? -unclipped[i] : unclipped[i];
         if (MAG_W'(mag) > peak_q[i]) peak_q[i] = MAG_W'(mag);
         if (MAG_W'(mag) > stress_q) stress_q = MAG_W'(mag);
         if (mag >= lim) begin
            clip_cnt_q[i] = sat_inc(clip_cnt_q[i]);
            integ_q[i] = STATE_W'((unclipped[i] > 0) ? lim : -lim);
            mask[i] = 1'b1;
         end else begin
            integ_q[i] = STATE_W'(unclipped[i]);
         end
      end
      if (mask != '0) events_q = sat_inc(events_q);
      r.dsd_bit = ~integ_q[NSTAGES-1][STATE_W-1];
      feedback_q = r.dsd_bit ? FB_POS : FB_NEG;
      r.clip_mask = mask;
      r.stage_peak = (sel < NSTAGES) ? peak_q[sel] : '0;
      r.stage_clip_count = (sel < NSTAGES) ? clip_cnt_q[sel] : '0;
      r.stress_peak = stress_q;
      r.period_samples = samples_q;
      r.period_clip_events = events_q;
      if (clear) clear_stats();
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         gain_q = GAIN_RESET;
         limit_q = LIMIT_RESET;
         for (int i = 0; i < NSTAGES; i++) integ_q[i] = '0;
         feedback_q = FB_ZERO;
         clear_stats();
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response with no request pending");
               error_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("dsd_bit", want.dsd_bit, rsp_dsd_bit);
               check_field("clip_mask", want.clip_mask, rsp_clip_mask);
               check_field("stage_peak", want.stage_peak, rsp_stage_peak);
               check_field("stage_clip_count", want.stage_clip_count, rsp_stage_clip_count);
               check_field("stress_peak", want.stress_peak, rsp_stress_peak);
               check_field("period_samples", want.period_samples, rsp_period_samples);
               check_field("period_clip_events", want.period_clip_events,
                           rsp_period_clip_events);
            end
         end
         if (req_valid && req_ready) begin
            modulate(req_audio_sample, req_clear_period, req_report_stage, want);
            expected_q.push_back(want);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               {REG_INPUT_GAIN, 2'b00}: gain_q = csr_pwdata[GAIN_W-1:0];
               {REG_CLIP_LIMIT, 2'b00}: limit_q = csr_pwdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count = expected_q.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the sigma-delta modulator testbench: clock, reset, request and register
// stimulus with random idling, and the final verdict. Depends on fosdm_pkg,
// fosdm_checker and the fifth_order_sigma_delta_modulator block.

module testbench;
   import fosdm_pkg::*;

   localparam int LATENCY = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 325;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_audio_sample = '0;
   logic                       req_clear_period = 1'b0;
   logic [2:0]                 req_report_stage = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_dsd_bit;
   logic [4:0]                 rsp_clip_mask;
   logic [24:0]                rsp_stage_peak;
   logic [31:0]                rsp_stage_clip_count;
   logic [24:0]                rsp_stress_peak;
   logic [31:0]                rsp_period_samples;
   logic [31:0]                rsp_period_clip_events;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [2:0]                 csr_paddr = '0;
   logic [31:0]                csr_pwdata = '0;
   logic [31:0]                csr_prdata;
   logic                       csr_pready;
   int                         error_count;
   int                         pending_count;
   int                         send_idle_pct = 14;
   int                         recv_idle_pct = 60;
   int                         cycle_count = 0;

   fifth_order_sigma_delta_modulator i_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_audio_sample, .req_clear_period, .req_report_stage,
      .rsp_valid, .rsp_ready, .rsp_dsd_bit, .rsp_clip_mask, .rsp_stage_peak,
      .rsp_stage_clip_count, .rsp_stress_peak, .rsp_period_samples,
      .rsp_period_clip_events,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_prdata,
      .csr_pready
   );

   fosdm_checker i_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_audio_sample, .req_clear_period, .req_report_stage,
      .rsp_valid, .rsp_ready, .rsp_dsd_bit, .rsp_clip_mask, .rsp_stage_peak,
      .rsp_stage_clip_count, .rsp_stress_peak, .rsp_period_samples,
      .rsp_period_clip_events,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .error_count, .pending_count
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_request(input logic signed [SAMPLE_W-1:0] sample, input logic clear,
                               input logic [2:0] stage);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_audio_sample <= sample;
      req_clear_period <= clear;
      req_report_stage <= stage;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // hold off requests until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] field_mask;
      field_mask = (idx == REG_INPUT_GAIN) ? 32'h3FFF : 32'h7F_FFFF;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= (value & field_mask) | ($urandom() & ~field_mask);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic signed [SAMPLE_W-1:0] sample;
      int random_count;
      int pick;
      random_count = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // drive the cascade into clipping at the reset settings
      for (int k = 0; k < 12; k++) send_request(SAMPLE_MAX, k == 8, 3'(k % 8));
      send_request(SAMPLE_MIN, 1'b0, 3'd5);
      send_request(SAMPLE_MIN, 1'b0, 3'd6);
      send_request(SAMPLE_MIN, 1'b0, 3'd7);
      send_request(SAMPLE_MIN, 1'b1, 3'd0);
      send_request(-24'sd1, 1'b0, 3'd1);
      send_request(24'sd1, 1'b0, 3'd2);
      send_request('0, 1'b1, 3'd4);

      // zero gain at the minimum limit: feedback alone reaches the limit exactly
      drain();
      write_reg(REG_INPUT_GAIN, 32'd0);
      write_reg(REG_CLIP_LIMIT, 32'd65536);
      for (int k = 0; k < 4; k++) send_request(SAMPLE_W'($urandom()), 1'b0, 3'(k));

      drain();
      write_reg(REG_INPUT_GAIN, 32'd16383);
      write_reg(REG_CLIP_LIMIT, 32'd6553600);
      send_request(SAMPLE_MAX, 1'b0, 3'd3);
      send_request(SAMPLE_MIN, 1'b0, 3'd4);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: begin
               write_reg(REG_INPUT_GAIN, 32'd16383);
               write_reg(REG_CLIP_LIMIT, 32'd65536);
            end
            1: begin
               write_reg(REG_INPUT_GAIN, 32'd0);
               write_reg(REG_CLIP_LIMIT, 32'd6553600);
            end
            2: begin
               write_reg(REG_INPUT_GAIN, $urandom_range(16383));
               write_reg(REG_CLIP_LIMIT, $urandom_range(65535));
            end
            3: begin
               write_reg(REG_INPUT_GAIN, $urandom_range(16383));
               write_reg(REG_CLIP_LIMIT, $urandom_range(8388607, 6553601));
            end
            4: begin
               write_reg(REG_INPUT_GAIN, $urandom_range(16383));
               write_reg(REG_CLIP_LIMIT, $urandom_range(6553600, 65536));
            end
            default: begin
               write_reg(REG_INPUT_GAIN, 32'd3277);
               write_reg(REG_CLIP_LIMIT, $urandom_range(6553600, 65536));
            end
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (random_count < 650) begin
               send_idle_pct = 14;
               recv_idle_pct = 60;
            end else if (random_count < 1300) begin
               send_idle_pct = 60;
               recv_idle_pct = 14;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            if ($urandom_range(249) == 0) drain();
            pick = $urandom_range(7);
            case (pick)
               0: sample = SAMPLE_MAX;
               1: sample = SAMPLE_MIN;
               2: sample = SAMPLE_W'($signed($urandom_range(255)) - 128);
               default: sample = SAMPLE_W'($urandom());
            endcase
            send_request(sample, $urandom_range(19) == 0, 3'($urandom_range(7)));
            random_count++;
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
